// File: sv/firt_pkg.sv
// Shared widths, command codes and the result word type of the fence retire tracker.
// No dependencies; the files that use it refer to this package by scoped names.
`default_nettype none

package firt_pkg;

    localparam int HANDLE_W          = 16;
    localparam int GEN_W             = 64;
    localparam int QUEUE_DEPTH_DEF   = 16;
    localparam int HANDLE_BITS_DEF   = 16;

    localparam logic [1:0] CMD_SUBMIT = 2'd0;
    localparam logic [1:0] CMD_SIGNAL = 2'd1;
    localparam logic [1:0] CMD_STOP   = 2'd2;

    typedef struct packed {
        logic                accepted;
        logic                release_valid;
        logic [HANDLE_W-1:0] release_handle;
        logic                advanced;
        logic [GEN_W-1:0]    ready_gen;
        logic [GEN_W-1:0]    submitted_gen;
        logic                stopped;
        logic                last;
    } t_result;

endpackage

`default_nettype wire

// File: sv/firt_cmd_if.sv
// Command channel of the fence retire tracker: valid/ready handshake plus command word.
// Depends on firt_pkg for the handle width.
`default_nettype none

interface firt_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    command;
    logic [firt_pkg::HANDLE_W-1:0] handle;

    modport source (output valid, output command, output handle, input ready);
    modport sink   (input valid, input command, input handle, output ready);
endinterface

`default_nettype wire

// File: sv/firt_res_if.sv
// Result channel of the fence retire tracker: valid/ready handshake plus result word.
// Depends on firt_pkg for the handle and generation widths.
`default_nettype none

interface firt_res_if;
    logic                          valid;
    logic                          ready;
    logic                          accepted;
    logic                          release_valid;
    logic [firt_pkg::HANDLE_W-1:0] release_handle;
    logic                          advanced;
    logic [firt_pkg::GEN_W-1:0]    ready_gen;
    logic [firt_pkg::GEN_W-1:0]    submitted_gen;
    logic                          scanout_ready;
    logic                          stopped;
    logic                          last;

    modport source (output valid, output accepted, output release_valid,
                    output release_handle, output advanced, output ready_gen,
                    output submitted_gen, output scanout_ready, output stopped,
                    output last, input ready);
    modport sink   (input valid, input accepted, input release_valid,
                    input release_handle, input advanced, input ready_gen,
                    input submitted_gen, input scanout_ready, input stopped,
                    input last, output ready);
endinterface

`default_nettype wire

// File: sv/fence_inorder_retire_tracker.sv
// Top level of the in-order fence retire tracker: sequencer, handle memory, output register.
// Depends on firt_pkg, firt_cmd_if, firt_res_if, firt_ctrl, firt_handle_mem, firt_out_reg.
//
// Fences are queued in submission order and retired from the head once signaled. One
// command word is taken at a time; the command port stays low until its results are
// loaded into the output register, which then waits for the sink while the next command
// is accepted. A signal compares pending entries in turn until one matches, reading them
// through the registered read port of the handle memory; it passes over entries already
// ready and then retires the ready entries at the head. A first stop walks the queue the
// same way and gives one result word per still-held handle, or a single word when none
// is held. A sink that holds ready low stalls the sequencer.
`default_nettype none

module fence_inorder_retire_tracker #(
    parameter int QUEUE_DEPTH = firt_pkg::QUEUE_DEPTH_DEF,
    parameter int HANDLE_BITS = firt_pkg::HANDLE_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    firt_cmd_if.sink   i_cmd,
    firt_res_if.source o_res
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int SW = (HANDLE_BITS < firt_pkg::HANDLE_W) ? HANDLE_BITS : firt_pkg::HANDLE_W;

    logic              emit;
    firt_pkg::t_result res_word;
    logic              out_free;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [SW-1:0]     wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [SW-1:0]     rd_data;

    firt_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd),
        .o_emit     (emit),
        .o_res_word (res_word),
        .i_out_free (out_free),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data)
    );

    firt_handle_mem #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (SW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    firt_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (emit),
        .i_res   (res_word),
        .o_free  (out_free),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

// File: sv/firt_handle_mem.sv
// Fence handle storage: one write port, one read port with registered read data.
// No package dependencies.
`default_nettype none

module firt_handle_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: sv/firt_out_reg.sv
// Result output register: holds one result word until taken, computes scanout readiness.
// Depends on firt_pkg (t_result) and firt_res_if.
`default_nettype none

module firt_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire firt_pkg::t_result i_res,
    output logic                   o_free,
    firt_res_if.source             o_res
);

    logic              r_valid;
    firt_pkg::t_result r_res;
    logic              r_scanout;
    logic              n_scanout;

    assign o_free    = !r_valid || o_res.ready;
    assign n_scanout = (i_res.submitted_gen == '0) || (i_res.ready_gen >= i_res.submitted_gen);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
        if (i_load) begin
            r_res     <= i_res;
            r_scanout <= n_scanout;
        end
    end

    assign o_res.valid          = r_valid;
    assign o_res.accepted       = r_res.accepted;
    assign o_res.release_valid  = r_res.release_valid;
    assign o_res.release_handle = r_res.release_handle;
    assign o_res.advanced       = r_res.advanced;
    assign o_res.ready_gen      = r_res.ready_gen;
    assign o_res.submitted_gen  = r_res.submitted_gen;
    assign o_res.scanout_ready  = r_scanout;
    assign o_res.stopped        = r_res.stopped;
    assign o_res.last           = r_res.last;

endmodule

`default_nettype wire

// File: sv/firt_ctrl.sv
// Sequencer of the fence retire tracker: queue pointers, ready bits, generation counters,
// and the entry-by-entry match, retire and flush walks. Depends on firt_pkg, firt_cmd_if.
`default_nettype none

module firt_ctrl #(
    parameter int QUEUE_DEPTH = firt_pkg::QUEUE_DEPTH_DEF,
    parameter int HANDLE_BITS = firt_pkg::HANDLE_BITS_DEF,
    localparam int AW = $clog2(QUEUE_DEPTH),
    localparam int SW = (HANDLE_BITS < firt_pkg::HANDLE_W) ? HANDLE_BITS : firt_pkg::HANDLE_W
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    firt_cmd_if.sink               i_cmd,
    output logic                   o_emit,
    output firt_pkg::t_result      o_res_word,
    input  wire logic              i_out_free,
    output logic                   o_wr_en,
    output logic [AW-1:0]          o_wr_addr,
    output logic [SW-1:0]          o_wr_data,
    output logic                   o_rd_en,
    output logic [AW-1:0]          o_rd_addr,
    input  wire logic [SW-1:0]     i_rd_data
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW:0]   DEPTH_X = (AW + 1)'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_IX = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CT = CW'(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_SC_CHK, S_SC_CMP, S_RETIRE, S_EMIT, S_FL_CHK, S_FL_GOT, S_FL_END
    } t_state;

    t_state                     r_state,   n_state;
    logic                       r_stop,    n_stop;
    logic [AW-1:0]              r_head,    n_head;
    logic [CW-1:0]              r_count,   n_count;
    logic [QUEUE_DEPTH-1:0]     r_ready,   n_ready;
    logic [firt_pkg::GEN_W-1:0] r_newest,  n_newest;
    logic [firt_pkg::GEN_W-1:0] r_retired, n_retired;
    logic [AW-1:0]              r_ptr,     n_ptr;
    logic [CW-1:0]              r_left,    n_left;
    logic [SW-1:0]              r_handle,  n_handle;
    logic                       r_acc,     n_acc;
    logic                       r_rel,     n_rel;
    logic [SW-1:0]              r_rel_h,   n_rel_h;
    logic                       r_adv,     n_adv;
    logic                       r_hold_v,  n_hold_v;
    logic [SW-1:0]              r_hold_h,  n_hold_h;

    logic [AW:0]   tail_sum;
    logic [AW-1:0] tail;
    logic          hit;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] p);
        f_next = (p == LAST_IX) ? '0 : p + 1'b1;
    endfunction

    assign tail_sum = {1'b0, r_head} + (AW + 1)'(r_count);
    assign tail     = (tail_sum >= DEPTH_X) ? AW'(tail_sum - DEPTH_X) : tail_sum[AW-1:0];
    assign hit      = (i_rd_data == r_handle);

    assign i_cmd.ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_stop    = r_stop;
        n_head    = r_head;
        n_count   = r_count;
        n_ready   = r_ready;
        n_newest  = r_newest;
        n_retired = r_retired;
        n_ptr     = r_ptr;
        n_left    = r_left;
        n_handle  = r_handle;
        n_acc     = r_acc;
        n_rel     = r_rel;
        n_rel_h   = r_rel_h;
        n_adv     = r_adv;
        n_hold_v  = r_hold_v;
        n_hold_h  = r_hold_h;
        o_emit    = 1'b0;
        o_wr_en   = 1'b0;
        o_wr_addr = tail;
        o_wr_data = i_cmd.handle[SW-1:0];
        o_rd_en   = 1'b0;
        o_rd_addr = r_ptr;
        o_res_word                = '0;
        o_res_word.ready_gen      = r_retired;
        o_res_word.submitted_gen  = r_newest;
        o_res_word.stopped        = r_stop;

        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_handle = i_cmd.handle[SW-1:0];
                    n_acc    = 1'b0;
                    n_rel    = 1'b0;
                    n_rel_h  = '0;
                    n_adv    = 1'b0;
                    n_ptr    = r_head;
                    n_left   = r_count;
                    n_hold_v = 1'b0;
                    n_state  = S_EMIT;
                    case (i_cmd.command)
                        firt_pkg::CMD_SUBMIT: begin
                            if (r_stop || r_count == FULL_CT) begin
                                n_rel   = 1'b1;
                                n_rel_h = i_cmd.handle[SW-1:0];
                            end else begin
                                o_wr_en       = 1'b1;
                                n_ready[tail] = 1'b0;
                                n_count       = r_count + 1'b1;
                                n_newest      = r_newest + 1'b1;
                                n_acc         = 1'b1;
                            end
                        end
                        firt_pkg::CMD_SIGNAL: begin
                            if (!r_stop) begin
                                n_state = S_SC_CHK;
                            end
                        end
                        firt_pkg::CMD_STOP: begin
                            if (!r_stop) begin
                                n_stop  = 1'b1;
                                n_state = S_FL_CHK;
                            end
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_SC_CHK: begin
                if (r_left == '0) begin
                    n_state = S_RETIRE;
                end else if (r_ready[r_ptr]) begin
                    n_ptr  = f_next(r_ptr);
                    n_left = r_left - 1'b1;
                end else begin
                    o_rd_en = 1'b1;
                    n_state = S_SC_CMP;
                end
            end
            S_SC_CMP: begin
                if (hit) begin
                    n_ready[r_ptr] = 1'b1;
                    n_acc          = 1'b1;
                    n_rel          = 1'b1;
                    n_rel_h        = r_handle;
                    n_state        = S_RETIRE;
                end else begin
                    n_ptr   = f_next(r_ptr);
                    n_left  = r_left - 1'b1;
                    n_state = S_SC_CHK;
                end
            end
            S_RETIRE: begin
                if (r_count != '0 && r_ready[r_head]) begin
                    n_ready[r_head] = 1'b0;
                    n_head          = f_next(r_head);
                    n_count         = r_count - 1'b1;
                    n_retired       = r_retired + 1'b1;
                    n_adv           = 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_out_free) begin
                    o_emit                    = 1'b1;
                    o_res_word.accepted       = r_acc;
                    o_res_word.release_valid  = r_rel;
                    o_res_word.release_handle = firt_pkg::HANDLE_W'(r_rel_h);
                    o_res_word.advanced       = r_adv;
                    o_res_word.last           = 1'b1;
                    n_state                   = S_IDLE;
                end
            end
            S_FL_CHK: begin
                if (r_left == '0) begin
                    n_state = S_FL_END;
                end else if (r_ready[r_ptr]) begin
                    n_ptr  = f_next(r_ptr);
                    n_left = r_left - 1'b1;
                end else begin
                    o_rd_en = 1'b1;
                    n_state = S_FL_GOT;
                end
            end
            S_FL_GOT: begin
                if (!r_hold_v || i_out_free) begin
                    o_emit                    = r_hold_v;
                    o_res_word.release_valid  = 1'b1;
                    o_res_word.release_handle = firt_pkg::HANDLE_W'(r_hold_h);
                    n_hold_v = 1'b1;
                    n_hold_h = i_rd_data;
                    n_ptr    = f_next(r_ptr);
                    n_left   = r_left - 1'b1;
                    n_state  = S_FL_CHK;
                end
            end
            S_FL_END: begin
                if (i_out_free) begin
                    o_emit                    = 1'b1;
                    o_res_word.release_valid  = r_hold_v;
                    o_res_word.release_handle = r_hold_v ?
                                                firt_pkg::HANDLE_W'(r_hold_h) : '0;
                    o_res_word.last           = 1'b1;
                    n_count = '0;
                    n_head  = '0;
                    n_ready = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_stop    <= 1'b0;
            r_head    <= '0;
            r_count   <= '0;
            r_ready   <= '0;
            r_newest  <= '0;
            r_retired <= '0;
            r_hold_v  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_stop    <= n_stop;
            r_head    <= n_head;
            r_count   <= n_count;
            r_ready   <= n_ready;
            r_newest  <= n_newest;
            r_retired <= n_retired;
            r_hold_v  <= n_hold_v;
        end
        r_ptr    <= n_ptr;
        r_left   <= n_left;
        r_handle <= n_handle;
        r_acc    <= n_acc;
        r_rel    <= n_rel;
        r_rel_h  <= n_rel_h;
        r_adv    <= n_adv;
        r_hold_h <= n_hold_h;
    end

endmodule

`default_nettype wire

// File: sv/firt_checker.sv
// Port-level checks for the fence retire tracker, attached to the top level by bind.
// Depends on firt_pkg for widths.
`default_nettype none

module firt_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_valid,
    input wire logic                          i_ready,
    input wire logic                          i_accepted,
    input wire logic                          i_release_valid,
    input wire logic [firt_pkg::HANDLE_W-1:0] i_release_handle,
    input wire logic                          i_advanced,
    input wire logic [firt_pkg::GEN_W-1:0]    i_ready_gen,
    input wire logic [firt_pkg::GEN_W-1:0]    i_submitted_gen,
    input wire logic                          i_scanout_ready,
    input wire logic                          i_stopped
);

    a_no_accept_when_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_stopped |-> !i_accepted && !i_advanced)
        else $error("word accepted or advanced while stopped");

    a_release_handle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_release_valid |-> i_release_handle == '0)
        else $error("release handle nonzero without release");

    a_scanout_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_scanout_ready ==
            ((i_submitted_gen == '0) || (i_ready_gen >= i_submitted_gen)))
        else $error("scanout readiness disagrees with generations");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_release_handle) && $stable(i_ready_gen))
        else $error("result word changed while stalled");

endmodule

bind fence_inorder_retire_tracker firt_checker u_firt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (o_res.valid),
    .i_ready          (o_res.ready),
    .i_accepted       (o_res.accepted),
    .i_release_valid  (o_res.release_valid),
    .i_release_handle (o_res.release_handle),
    .i_advanced       (o_res.advanced),
    .i_ready_gen      (o_res.ready_gen),
    .i_submitted_gen  (o_res.submitted_gen),
    .i_scanout_ready  (o_res.scanout_ready),
    .i_stopped        (o_res.stopped)
);

`default_nettype wire

// File: test/fence_inorder_retire_tracker_test.sv
// Self-checking bench for fence_inorder_retire_tracker: drives submit, signal, stop and spare
// command words and compares every result word against an in-bench fence queue tracker.
// Depends on firt_pkg, firt_cmd_if and firt_res_if.
`timescale 1ns / 1ps

module fence_inorder_retire_tracker_test;

    localparam int HANDLE_W = firt_pkg::HANDLE_W;
    localparam int GEN_W    = firt_pkg::GEN_W;
    localparam int DEPTH    = firt_pkg::QUEUE_DEPTH_DEF;
    localparam logic [HANDLE_W-1:0] HANDLE_MASK =
        HANDLE_W'((64'd1 << firt_pkg::HANDLE_BITS_DEF) - 64'd1);
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int STALL_LIMIT = 3000;

    typedef struct packed {
        logic                accepted;
        logic                release_valid;
        logic [HANDLE_W-1:0] release_handle;
        logic                advanced;
        logic [GEN_W-1:0]    ready_gen;
        logic [GEN_W-1:0]    submitted_gen;
        logic                scanout_ready;
        logic                stopped;
        logic                last;
    } t_fence_status;

    class t_fence_ledger;
        logic [HANDLE_W-1:0] slot_handle[DEPTH];
        bit                  slot_ready[DEPTH];
        int                  head = 0;
        int                  fill = 0;
        logic [GEN_W-1:0]    newest_gen = '0;
        logic [GEN_W-1:0]    retired_gen = '0;
        bit                  halted = 0;
        t_fence_status       due_status[$];
        int                  mismatches = 0;
        int                  n_submit = 0;
        int                  n_refused = 0;
        int                  n_signal = 0;
        int                  n_matched = 0;
        int                  n_stop = 0;
        int                  n_other = 0;
        int                  n_checked = 0;

        function void queue_status(bit acc, bit rel, logic [HANDLE_W-1:0] hnd, bit adv,
                                   bit fin);
            t_fence_status s;
            s.accepted       = acc;
            s.release_valid  = rel;
            s.release_handle = rel ? hnd : '0;
            s.advanced       = adv;
            s.ready_gen      = retired_gen;
            s.submitted_gen  = newest_gen;
            s.scanout_ready  = (newest_gen == '0) || (retired_gen >= newest_gen);
            s.stopped        = halted;
            s.last           = fin;
            due_status.insert(due_status.size(), s);
        endfunction

        function int pending_count();
            int n;
            n = 0;
            for (int i = 0; i < fill; i++)
                if (!slot_ready[(head + i) % DEPTH]) n++;
            return n;
        endfunction

        function logic [HANDLE_W-1:0] pick_pending();
            int k;
            int p;
            k = $urandom_range(0, pending_count() - 1);
            for (int i = 0; i < fill; i++) begin
                p = (head + i) % DEPTH;
                if (!slot_ready[p]) begin
                    if (k == 0) return slot_handle[p];
                    k--;
                end
            end
            return '0;
        endfunction

        function void note_command(logic [1:0] code, logic [HANDLE_W-1:0] raw);
            logic [HANDLE_W-1:0] hnd;
            logic [HANDLE_W-1:0] held[$];
            bit matched;
            bit adv;
            int p;
            hnd = raw & HANDLE_MASK;
            matched = 0;
            adv = 0;
            case (code)
                firt_pkg::CMD_SUBMIT: begin
                    n_submit++;
                    if (halted || fill >= DEPTH) begin
                        n_refused++;
                        queue_status(0, 1, hnd, 0, 1);
                    end else begin
                        p = (head + fill) % DEPTH;
                        slot_handle[p] = hnd;
                        slot_ready[p] = 0;
                        fill++;
                        newest_gen++;
                        queue_status(1, 0, '0, 0, 1);
                    end
                end
                firt_pkg::CMD_SIGNAL: begin
                    n_signal++;
                    if (!halted) begin
                        for (int i = 0; i < fill; i++) begin
                            p = (head + i) % DEPTH;
                            if (!slot_ready[p] && slot_handle[p] == hnd) begin
                                slot_ready[p] = 1;
                                matched = 1;
                                break;
                            end
                        end
                        while (fill > 0 && slot_ready[head]) begin
                            slot_ready[head] = 0;
                            head = (head + 1) % DEPTH;
                            fill--;
                            retired_gen++;
                            adv = 1;
                        end
                    end
                    if (matched) n_matched++;
                    queue_status(matched, matched, hnd, adv, 1);
                end
                firt_pkg::CMD_STOP: begin
                    n_stop++;
                    if (halted) begin
                        queue_status(0, 0, '0, 0, 1);
                    end else begin
                        for (int i = 0; i < fill; i++) begin
                            p = (head + i) % DEPTH;
                            if (!slot_ready[p]) held.insert(held.size(), slot_handle[p]);
                            slot_ready[p] = 0;
                        end
                        halted = 1;
                        fill = 0;
                        head = 0;
                        if (held.size() == 0)
                            queue_status(0, 0, '0, 0, 1);
                        for (int i = 0; i < held.size(); i++)
                            queue_status(0, 1, held[i], 0, i == held.size() - 1);
                    end
                end
                default: begin
                    n_other++;
                    queue_status(0, 0, '0, 0, 1);
                end
            endcase
        endfunction

        function void compare_field(string name, logic [GEN_W-1:0] want,
                                    logic [GEN_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_status(t_fence_status got);
            t_fence_status want;
            if (due_status.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, got);
                mismatches++;
                return;
            end
            want = due_status[0];
            due_status.delete(0);
            n_checked++;
            compare_field("accepted", GEN_W'(want.accepted), GEN_W'(got.accepted));
            compare_field("release_valid", GEN_W'(want.release_valid),
                          GEN_W'(got.release_valid));
            compare_field("release_handle", GEN_W'(want.release_handle),
                          GEN_W'(got.release_handle));
            compare_field("advanced", GEN_W'(want.advanced), GEN_W'(got.advanced));
            compare_field("ready_gen", want.ready_gen, got.ready_gen);
            compare_field("submitted_gen", want.submitted_gen, got.submitted_gen);
            compare_field("scanout_ready", GEN_W'(want.scanout_ready),
                          GEN_W'(got.scanout_ready));
            compare_field("stopped", GEN_W'(want.stopped), GEN_W'(got.stopped));
            compare_field("last", GEN_W'(want.last), GEN_W'(got.last));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    firt_cmd_if cmd_if();
    firt_res_if res_if();

    fence_inorder_retire_tracker uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    t_fence_ledger       sb;
    int                  tx_idle_pct;
    int                  rx_idle_pct;
    int                  rx_hold_request;
    int                  rx_hold_left;
    int                  quiet_cycles;
    logic [HANDLE_W-1:0] favored[4];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic send_word(input logic [1:0] code, input logic [HANDLE_W-1:0] hnd);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            cmd_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.command <= code;
        cmd_if.handle  <= hnd;
        do @(posedge i_clk); while (!cmd_if.ready);
        sb.note_command(code, hnd);
    endtask

    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.due_status.size() != 0);
    endtask

    function automatic logic [HANDLE_W-1:0] submit_handle();
        if ($urandom_range(0, 99) < 40) return favored[$urandom_range(0, 3)];
        return HANDLE_W'($urandom_range(0, 65535));
    endfunction

    task automatic send_random_word();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            send_word(CMD_SPARE, HANDLE_W'($urandom_range(0, 65535)));
        else if (roll < 12)
            send_word(firt_pkg::CMD_SIGNAL, HANDLE_W'($urandom_range(0, 65535)));
        else if (sb.pending_count() == 0 || (roll < 56 && sb.fill < DEPTH) || roll < 60)
            send_word(firt_pkg::CMD_SUBMIT, submit_handle());
        else
            send_word(firt_pkg::CMD_SIGNAL, sb.pick_pending());
    endtask

    initial begin
        rx_hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready)
                sb.check_status({res_if.accepted, res_if.release_valid,
                                 res_if.release_handle, res_if.advanced,
                                 res_if.ready_gen, res_if.submitted_gen,
                                 res_if.scanout_ready, res_if.stopped, res_if.last});
            if (rx_hold_request > 0) begin
                rx_hold_left = rx_hold_request;
                rx_hold_request = 0;
            end
            if (rx_hold_left > 0) begin
                res_if.ready <= 1'b0;
                rx_hold_left--;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        sb = new();
        tx_idle_pct = 28;
        rx_idle_pct = 65;
        rx_hold_request = 0;
        foreach (favored[i]) favored[i] = HANDLE_W'($urandom_range(0, 65535));
        i_rst_n        <= 1'b0;
        cmd_if.valid   <= 1'b0;
        cmd_if.command <= firt_pkg::CMD_SUBMIT;
        cmd_if.handle  <= '0;
        res_if.ready   <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(firt_pkg::CMD_SIGNAL, 16'h0000);
        send_word(CMD_SPARE, 16'hFFFF);
        send_word(firt_pkg::CMD_SUBMIT, 16'h0000);
        send_word(firt_pkg::CMD_SUBMIT, 16'hFFFF);
        send_word(firt_pkg::CMD_SUBMIT, 16'hFFFF);
        send_word(firt_pkg::CMD_SIGNAL, 16'hFFFF);
        send_word(firt_pkg::CMD_SIGNAL, 16'h0000);
        send_word(firt_pkg::CMD_SIGNAL, 16'hFFFF);
        repeat (DEPTH + 1)
            send_word(firt_pkg::CMD_SUBMIT, HANDLE_W'($urandom_range(0, 65535)));
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 65 : 0;
            rx_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 28 : 0;
            repeat (25) send_random_word();
            wait_drained();
        end

        // hold the result side while submits keep coming
        rx_hold_request = 400;
        repeat (20) send_word(firt_pkg::CMD_SUBMIT, submit_handle());
        wait_drained();

        tx_idle_pct = 28;
        rx_idle_pct = 65;
        while (sb.fill < DEPTH) send_word(firt_pkg::CMD_SUBMIT, submit_handle());
        repeat (3) send_word(firt_pkg::CMD_SIGNAL, sb.pick_pending());
        send_word(firt_pkg::CMD_STOP, HANDLE_W'($urandom_range(0, 65535)));
        send_word(firt_pkg::CMD_SUBMIT, submit_handle());
        send_word(firt_pkg::CMD_SIGNAL, favored[0]);
        send_word(firt_pkg::CMD_STOP, '0);
        send_word(CMD_SPARE, '0);
        wait_drained();
        repeat (60) @(posedge i_clk);

        if (sb.due_status.size() != 0) begin
            $display("%0t: %0d expected result words never arrived",
                     $time, sb.due_status.size());
            sb.mismatches++;
        end
        $display("Covered %0d submits (%0d refused), %0d signals (%0d matched), %0d stops,",
                 sb.n_submit, sb.n_refused, sb.n_signal, sb.n_matched, sb.n_stop);
        $display("%0d spare commands; %0d result words checked, ready generation %0d.",
                 sb.n_other, sb.n_checked, sb.retired_gen);
        if (sb.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/firt_pkg.sv
sv/firt_cmd_if.sv
sv/firt_res_if.sv
sv/firt_handle_mem.sv
sv/firt_out_reg.sv
sv/firt_ctrl.sv
sv/fence_inorder_retire_tracker.sv
sv/firt_checker.sv
test/fence_inorder_retire_tracker_test.sv
